### src/ycta_pkg.sv
package ycta_pkg;

  // Register indexes on the configuration channel
  localparam logic [1:0] CFG_THRESH_TRANSPARENT = 2'd0;
  localparam logic [1:0] CFG_THRESH_HALF_ALPHA  = 2'd1;
  localparam logic [1:0] CFG_SIGNED_OUTPUT      = 2'd2;

  // BT.601 fixed-point constants, scale 2^7
  localparam logic [7:0]         Y_BIAS    = 8'd16;
  localparam logic [7:0]         Y_COEFF   = 8'h95;
  localparam logic signed [10:0] RCR_COEFF = 11'sd204;
  localparam logic signed [10:0] GCR_COEFF = -11'sd104;
  localparam logic signed [10:0] GCB_COEFF = -11'sd50;
  localparam logic signed [10:0] BCB_COEFF = 11'sd258;
  localparam logic signed [8:0]  C_BIAS    = 9'sd128;

  localparam logic [7:0] ALPHA_NORMAL = 8'h80;
  localparam logic [7:0] ALPHA_HALF   = 8'h40;
  localparam logic [7:0] SIGN_FLIP    = 8'h80;
  localparam logic [7:0] CHAN_MAX     = 8'd255;

  typedef struct packed {
    logic [8:0] thresh_transparent;
    logic [8:0] thresh_half_alpha;
    logic       signed_output;
  } cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

### src/ycta_pix_if.sv
interface ycta_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

### src/ycta_rgba_if.sv
interface ycta_rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

### src/ycta_cfg_if.sv
interface ycta_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/ycta_cfg_regs.sv
module ycta_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_index_i,
  input  logic [8:0]        wr_data_i,
  output ycta_pkg::cfg_t    cfg_o
);

  ycta_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        ycta_pkg::CFG_THRESH_TRANSPARENT: cfg_d.thresh_transparent = wr_data_i;
        ycta_pkg::CFG_THRESH_HALF_ALPHA:  cfg_d.thresh_half_alpha  = wr_data_i;
        ycta_pkg::CFG_SIGNED_OUTPUT:      cfg_d.signed_output      = wr_data_i[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/ycta_convert.sv
module ycta_convert (
  input  ycta_pkg::pixel_t pix_i,
  input  ycta_pkg::cfg_t   cfg_i,
  output ycta_pkg::rgba_t  rgba_o
);

  logic [7:0]         ys;
  logic [15:0]        lum_p;
  logic [9:0]         lum;
  logic signed [8:0]  cb, cr;
  logic signed [19:0] rcr_p, gcr_p, gcb_p, bcb_p;
  logic signed [13:0] rcr, gcr, gcb, bcb, lum_s;
  logic signed [13:0] r_sum, g_sum, b_sum;
  logic [7:0]         r, g, b, r_o, g_o, b_o, a;
  logic               below_t, below_h;

  function automatic logic [7:0] clamp_byte(input logic signed [13:0] v);
    logic signed [13:0] h;
    h = v >>> 1;  // floor halve
    if (h < 0) begin
      clamp_byte = '0;
    end else if (h > 14'sd255) begin
      clamp_byte = ycta_pkg::CHAN_MAX;
    end else begin
      clamp_byte = h[7:0];
    end
  endfunction

  always_comb begin
    ys    = (pix_i.luma > ycta_pkg::Y_BIAS) ? pix_i.luma - ycta_pkg::Y_BIAS : '0;
    lum_p = 16'(ys) * 16'(ycta_pkg::Y_COEFF);
    lum   = lum_p[15:6];

    cb = $signed({1'b0, pix_i.chroma_blue}) - ycta_pkg::C_BIAS;
    cr = $signed({1'b0, pix_i.chroma_red})  - ycta_pkg::C_BIAS;

    rcr_p = 20'(cr) * 20'(ycta_pkg::RCR_COEFF);
    gcr_p = 20'(cr) * 20'(ycta_pkg::GCR_COEFF);
    gcb_p = 20'(cb) * 20'(ycta_pkg::GCB_COEFF);
    bcb_p = 20'(cb) * 20'(ycta_pkg::BCB_COEFF);

    // arithmetic shift is a floor divide by 64
    rcr = 14'(rcr_p >>> 6);
    gcr = 14'(gcr_p >>> 6);
    gcb = 14'(gcb_p >>> 6);
    bcb = 14'(bcb_p >>> 6);

    lum_s = $signed({4'b0, lum});
    r_sum = lum_s + rcr + 14'sd1;
    g_sum = lum_s + gcr + gcb + 14'sd1;
    b_sum = lum_s + bcb + 14'sd1;

    r = clamp_byte(r_sum);
    g = clamp_byte(g_sum);
    b = clamp_byte(b_sum);

    below_t = ({1'b0, r} < cfg_i.thresh_transparent) &&
              ({1'b0, g} < cfg_i.thresh_transparent) &&
              ({1'b0, b} < cfg_i.thresh_transparent);
    below_h = ({1'b0, r} < cfg_i.thresh_half_alpha) &&
              ({1'b0, g} < cfg_i.thresh_half_alpha) &&
              ({1'b0, b} < cfg_i.thresh_half_alpha);

    r_o = r;
    g_o = g;
    b_o = b;
    a   = ycta_pkg::ALPHA_NORMAL;
    if (below_t) begin
      r_o = '0;
      g_o = '0;
      b_o = '0;
      a   = '0;
    end else if (below_h) begin
      a = ycta_pkg::ALPHA_HALF;
    end
    if (cfg_i.signed_output) begin
      r_o = r_o ^ ycta_pkg::SIGN_FLIP;
      g_o = g_o ^ ycta_pkg::SIGN_FLIP;
      b_o = b_o ^ ycta_pkg::SIGN_FLIP;
    end

    rgba_o.red   = r_o;
    rgba_o.green = g_o;
    rgba_o.blue  = b_o;
    rgba_o.alpha = a;
  end

endmodule

### src/ycbcr_to_rgba_with_alpha_thresholds.sv
// Channel  Dir  Payload                           Transfer
// pix_i    in   luma, chroma_blue, chroma_red     valid & ready
// rgba_o   out  red, green, blue, alpha           valid & ready
// cfg_i    in   index (2b), data (9b)             valid & ready, ready always high
//
// Datapath: pixel register, then conversion into the result register.
// Throughput one pixel per cycle while rgba_o is not stalled; an empty stage loads even if the next holds.
// Reset (rst_ni low, async) empties both stages and zeroes the configuration; payloads are not reset.
// A stall on rgba_o holds the result; pix_i still takes a pixel while stage 1 is empty.
module ycbcr_to_rgba_with_alpha_thresholds (
  input  logic                clk_i,
  input  logic                rst_ni,
  ycta_pix_if.sink            pix_i,
  ycta_rgba_if.source         rgba_o,
  ycta_cfg_if.sink            cfg_i
);

  ycta_pkg::cfg_t   cfg;
  ycta_pkg::pixel_t pix_q;
  ycta_pkg::rgba_t  rgba_d, rgba_q;
  logic             pix_vld_q, rgba_vld_q;
  logic             adv_out, adv_in;

  // Configuration: always ready, writes land next edge.
  assign cfg_i.ready = 1'b1;

  ycta_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Result stage loads when empty or when its contents are being taken.
  assign adv_out     = !rgba_vld_q || rgba_o.ready;
  // Pixel stage loads when empty or when it drains into the result stage.
  assign adv_in      = !pix_vld_q || adv_out;
  assign pix_i.ready = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q  <= 1'b0;
      rgba_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        pix_vld_q <= pix_i.valid;
      end
      if (adv_out) begin
        rgba_vld_q <= pix_vld_q;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (adv_in && pix_i.valid) begin
      pix_q.luma        <= pix_i.luma;
      pix_q.chroma_blue <= pix_i.chroma_blue;
      pix_q.chroma_red  <= pix_i.chroma_red;
    end
    if (adv_out && pix_vld_q) begin
      rgba_q <= rgba_d;
    end
  end

  // Conversion, thresholds and sign flip between the two registers.
  ycta_convert u_conv (
    .pix_i  (pix_q),
    .cfg_i  (cfg),
    .rgba_o (rgba_d)
  );

  assign rgba_o.valid = rgba_vld_q;
  assign rgba_o.red   = rgba_q.red;
  assign rgba_o.green = rgba_q.green;
  assign rgba_o.blue  = rgba_q.blue;
  assign rgba_o.alpha = rgba_q.alpha;

endmodule

### src/ycta_checker.sv
module ycta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i
);

  logic [2:0] inflight_q, inflight_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_xfer && !out_xfer) begin
      inflight_d = inflight_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // no invented result, at most two pixels buffered
  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i |-> inflight_q != 3'd0) and (inflight_q <= 3'd2))
    else $error("pixel count mismatch");

  // alpha is one of the three levels
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (alpha_i == 8'h00 || alpha_i == 8'h40 || alpha_i == 8'h80))
    else $error("bad alpha");

  // transparent pixel has equal channels, zero or sign-flipped zero
  a_transparent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && alpha_i == 8'h00 |->
      red_i == green_i && green_i == blue_i && (red_i == 8'h00 || red_i == 8'h80))
    else $error("transparent pixel not cleared");

endmodule

bind ycbcr_to_rgba_with_alpha_thresholds ycta_checker u_ycta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (rgba_o.valid),
  .out_ready_i (rgba_o.ready),
  .red_i       (rgba_o.red),
  .green_i     (rgba_o.green),
  .blue_i      (rgba_o.blue),
  .alpha_i     (rgba_o.alpha)
);
